// ----- rtl/osfb_pkg.sv -----
// Shared types, constants and key table for the serial frame builder.
package osfb_pkg;

    localparam int unsigned LEN_W               = 9;
    localparam int unsigned MAX_FRAME_BYTES_DEF = 256;
    localparam int unsigned QUEUE_DEPTH         = 4;

    localparam logic [7:0] HDR_LO   = 8'hAB;
    localparam logic [7:0] HDR_HI   = 8'hCD;
    localparam logic [7:0] FTR_LO   = 8'hDC;
    localparam logic [7:0] FTR_HI   = 8'hBA;
    localparam logic [7:0] PAD_BYTE = 8'hFF;

    typedef struct packed {
        logic [7:0]       payload_byte;
        logic [LEN_W-1:0] frame_length;
    } t_in_item;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       run_last;
        logic       frame_done;
    } t_out_item;

    // Classified transaction handed from front to back
    typedef struct packed {
        logic             first;
        logic             last;
        logic [LEN_W-1:0] len;
        logic [7:0]       data;
        logic [7:0]       pad0;
        logic [7:0]       pad1;
    } t_entry;

    typedef enum logic [3:0] {
        ST_START,
        ST_HDR0,
        ST_HDR1,
        ST_LEN0,
        ST_LEN1,
        ST_DATA,
        ST_PAD0,
        ST_PAD1,
        ST_FTR0,
        ST_FTR1
    } t_step;

    function automatic logic [7:0] key_byte(input logic [3:0] idx);
        logic [7:0] k;
        case (idx)
            4'd0:  k = 8'h16;
            4'd1:  k = 8'h6C;
            4'd2:  k = 8'h14;
            4'd3:  k = 8'hE6;
            4'd4:  k = 8'h2E;
            4'd5:  k = 8'h91;
            4'd6:  k = 8'h0D;
            4'd7:  k = 8'h40;
            4'd8:  k = 8'h21;
            4'd9:  k = 8'h35;
            4'd10: k = 8'hD5;
            4'd11: k = 8'h40;
            4'd12: k = 8'h13;
            4'd13: k = 8'h03;
            4'd14: k = 8'hE9;
            4'd15: k = 8'h80;
            default: k = 8'h00;
        endcase
        return k;
    endfunction

endpackage

// ----- rtl/obfuscated_serial_frame_builder.sv -----
// Serial transmit frame builder with optional XOR obfuscation of payload and pad bytes.
//
// Each input transaction carries one payload byte; frame_length is sampled on
// the first byte of a frame (0 is taken as 1, values above MAX_FRAME_BYTES
// saturate). The output stream per frame is: AB CD, length low, length high,
// the payload bytes (each XORed with key[pos mod 16] when obfuscation is on),
// two pad bytes (FF XORed with key[len mod 16] and key[(len+1) mod 16] when
// on), then DC BA with frame_done set on BA. run_last marks the final output
// transaction caused by each input transaction. Obfuscation is sampled when
// the input transaction is accepted; change it only while idle.
//
// Throughput: the back end emits one output byte per clock unless the output
// stalls. A mid-frame payload byte yields one output byte, a frame's first byte
// five, its last byte five, a single-byte frame nine. The front end accepts one
// transaction per clock while the queue is not full, into a four-entry queue, so
// bursts of payload bytes flow at full rate and header/footer bytes stall the
// input only once it fills. Entries are queued before the registered output slot.
module obfuscated_serial_frame_builder #(
    parameter int unsigned MAX_FRAME_BYTES = osfb_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Configuration: obfuscate_enable
    input  logic                i_cfg_we,
    input  logic                i_cfg_data,
    // Input channel
    input  logic                i_in_valid,
    input  osfb_pkg::t_in_item  i_in_item,
    output logic                o_in_ready,
    // Output channel
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output osfb_pkg::t_out_item o_result
);

    osfb_pkg::t_entry entry, head;
    logic             push, pop, q_full, q_empty;

    // Front: position tracking, length latch, keying
    osfb_front #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_in_ready (o_in_ready),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_entry    (entry)
    );

    // Decoupling queue so the front keeps accepting while the back expands
    osfb_queue #(
        .DEPTH (osfb_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Back: byte sequencer and registered output slot
    osfb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_q_empty   (q_empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (o_result)
    );

endmodule

// ----- rtl/osfb_front.sv -----
// Front end: accepts payload transactions, tracks frame position, applies the key.
module osfb_front #(
    parameter int unsigned MAX_FRAME_BYTES = osfb_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_data,
    input  logic              i_in_valid,
    input  osfb_pkg::t_in_item i_in_item,
    output logic              o_in_ready,
    input  logic              i_q_full,
    output logic              o_push,
    output osfb_pkg::t_entry  o_entry
);

    logic                         r_obf;
    logic [osfb_pkg::LEN_W-1:0]   r_byte_pos, n_byte_pos;
    logic [osfb_pkg::LEN_W-1:0]   r_len, n_len;
    logic [osfb_pkg::LEN_W-1:0]   len_raw, len_sat, len_cur;
    logic [osfb_pkg::LEN_W:0]     pos_inc;
    logic [7:0]                   key_mask, pad0_mask, pad1_mask;
    logic [3:0]                   pad1_idx;
    logic                         accept, first, last;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign o_push     = accept;

    always_comb begin
        len_raw = i_in_item.frame_length;
        if (len_raw == '0) begin
            len_sat = osfb_pkg::LEN_W'(1);
        end else if (32'(len_raw) > 32'(MAX_FRAME_BYTES)) begin
            len_sat = osfb_pkg::LEN_W'(MAX_FRAME_BYTES);
        end else begin
            len_sat = len_raw;
        end
        first    = (r_byte_pos == '0);
        len_cur  = first ? len_sat : r_len;
        pos_inc  = {1'b0, r_byte_pos} + (osfb_pkg::LEN_W+1)'(1);
        last     = (pos_inc >= {1'b0, len_cur});
        pad1_idx = len_cur[3:0] + 4'd1;

        key_mask  = r_obf ? osfb_pkg::key_byte(r_byte_pos[3:0]) : 8'h00;
        pad0_mask = r_obf ? osfb_pkg::key_byte(len_cur[3:0])    : 8'h00;
        pad1_mask = r_obf ? osfb_pkg::key_byte(pad1_idx)        : 8'h00;

        o_entry.first = first;
        o_entry.last  = last;
        o_entry.len   = len_cur;
        o_entry.data  = i_in_item.payload_byte ^ key_mask;
        o_entry.pad0  = osfb_pkg::PAD_BYTE ^ pad0_mask;
        o_entry.pad1  = osfb_pkg::PAD_BYTE ^ pad1_mask;

        n_byte_pos = r_byte_pos;
        n_len      = r_len;
        if (accept) begin
            n_len      = len_cur;
            n_byte_pos = last ? '0 : pos_inc[osfb_pkg::LEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obf      <= 1'b1;
            r_byte_pos <= '0;
            r_len      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_obf <= i_cfg_data;
            end
            r_byte_pos <= n_byte_pos;
            r_len      <= n_len;
        end
    end

endmodule

// ----- rtl/osfb_queue.sv -----
// Small FIFO of classified transactions between front and back.
module osfb_queue #(
    parameter int unsigned DEPTH = osfb_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  osfb_pkg::t_entry i_entry,
    input  logic             i_pop,
    output osfb_pkg::t_entry o_head,
    output logic             o_full,
    output logic             o_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    osfb_pkg::t_entry   r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (32'(r_wr_ptr) == DEPTH - 1) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (32'(r_rd_ptr) == DEPTH - 1) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- rtl/osfb_back.sv -----
// Back end: sequences header, payload, pad and footer bytes into the output register.
module osfb_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  osfb_pkg::t_entry   i_head,
    input  logic               i_q_empty,
    output logic               o_pop,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output osfb_pkg::t_out_item o_result
);

    osfb_pkg::t_step     r_step, n_step, cur_step, step_after;
    osfb_pkg::t_out_item r_result, n_result;
    logic                r_out_valid, n_out_valid;
    logic                load, entry_end;

    always_comb begin
        cur_step = r_step;
        if (r_step == osfb_pkg::ST_START) begin
            cur_step = i_head.first ? osfb_pkg::ST_HDR0 : osfb_pkg::ST_DATA;
        end

        n_result.tx_byte    = 8'h00;
        n_result.frame_done = 1'b0;
        entry_end           = 1'b0;
        step_after          = osfb_pkg::ST_START;
        case (cur_step)
            osfb_pkg::ST_HDR0: begin
                n_result.tx_byte = osfb_pkg::HDR_LO;
                step_after       = osfb_pkg::ST_HDR1;
            end
            osfb_pkg::ST_HDR1: begin
                n_result.tx_byte = osfb_pkg::HDR_HI;
                step_after       = osfb_pkg::ST_LEN0;
            end
            osfb_pkg::ST_LEN0: begin
                n_result.tx_byte = i_head.len[7:0];
                step_after       = osfb_pkg::ST_LEN1;
            end
            osfb_pkg::ST_LEN1: begin
                n_result.tx_byte = 8'(i_head.len >> 8);
                step_after       = osfb_pkg::ST_DATA;
            end
            osfb_pkg::ST_DATA: begin
                n_result.tx_byte = i_head.data;
                entry_end        = !i_head.last;
                step_after       = osfb_pkg::ST_PAD0;
            end
            osfb_pkg::ST_PAD0: begin
                n_result.tx_byte = i_head.pad0;
                step_after       = osfb_pkg::ST_PAD1;
            end
            osfb_pkg::ST_PAD1: begin
                n_result.tx_byte = i_head.pad1;
                step_after       = osfb_pkg::ST_FTR0;
            end
            osfb_pkg::ST_FTR0: begin
                n_result.tx_byte = osfb_pkg::FTR_LO;
                step_after       = osfb_pkg::ST_FTR1;
            end
            osfb_pkg::ST_FTR1: begin
                n_result.tx_byte    = osfb_pkg::FTR_HI;
                n_result.frame_done = 1'b1;
                entry_end           = 1'b1;
            end
            default: begin
                entry_end = 1'b1;
            end
        endcase
        n_result.run_last = entry_end;

        // Output slot loads when the queue has an entry and the slot is empty or being drained this cycle
        load  = !i_q_empty && (!r_out_valid || i_out_ready);
        o_pop = load && entry_end;

        n_step = r_step;
        if (load) begin
            n_step = entry_end ? osfb_pkg::ST_START : step_after;
        end

        n_out_valid = r_out_valid;
        if (load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= osfb_pkg::ST_START;
            r_out_valid <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule
